// ----- design/zero_cross_triac_trigger_macros.svh -----
// ----------------------------------------------------------------------------
// Zero-cross triac trigger assertion macros
// Shorthand for the concurrent checks used on the block's ports.
// ----------------------------------------------------------------------------
`ifndef ZERO_CROSS_TRIAC_TRIGGER_MACROS_SVH
`define ZERO_CROSS_TRIAC_TRIGGER_MACROS_SVH

// check outside reset
`define ZCT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that also covers the reset cycles
`define ZCT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- design/zct_pkg.sv -----
// ----------------------------------------------------------------------------
// Zero-cross triac trigger package
// Shared types, register indexes and constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package zct_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int BLANK_LIMIT = 100;
   localparam int ARM_TICK    = 2;
   localparam int BLANK_W     = $clog2(BLANK_LIMIT + 1);
   localparam int REG_W       = 16;
   localparam int PERIOD_W    = 16;
   localparam int INDEX_W     = 3;

   localparam logic [REG_W-1:0] RST_FIRST_CROSS_DELAY = 16'd1000;
   localparam logic [REG_W-1:0] RST_TIMEOUT_TICKS     = 16'd30000;
   localparam logic [REG_W-1:0] RST_PULSE_TICKS       = 16'd100;
   localparam logic [REG_W-1:0] RST_PERIOD_MIN        = 16'd15000;
   localparam logic [REG_W-1:0] RST_PERIOD_MAX        = 16'd25000;

   localparam logic [INDEX_W-1:0] REG_FIRST_CROSS_DELAY = 3'd0;
   localparam logic [INDEX_W-1:0] REG_TIMEOUT_TICKS     = 3'd1;
   localparam logic [INDEX_W-1:0] REG_PULSE_TICKS       = 3'd2;
   localparam logic [INDEX_W-1:0] REG_PERIOD_MIN        = 3'd3;
   localparam logic [INDEX_W-1:0] REG_PERIOD_MAX        = 3'd4;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_EDGE  = 2'd1;
   localparam logic [1:0] MODE_COUNT = 2'd2;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [2:0] {
      PH_FIRST  = 3'd0,
      PH_PULSE1 = 3'd1,
      PH_SECOND = 3'd2,
      PH_PULSE2 = 3'd3,
      PH_WAIT   = 3'd4,
      PH_IDLE   = 3'd5
   } phase_type;

   typedef struct packed {
      logic [REG_W-1:0] first_cross_delay;
      logic [REG_W-1:0] timeout_ticks;
      logic [REG_W-1:0] pulse_ticks;
      logic [REG_W-1:0] period_min;
      logic [REG_W-1:0] period_max;
   } cfg_type;

   typedef struct packed {
      logic                gate_on;
      logic [PERIOD_W-1:0] measured_period;
      logic [2:0]          phase;
      logic                edge_armed;
   } res_type;

endpackage

// ----- design/zct_cfg.sv -----
// ----------------------------------------------------------------------------
// Zero-cross triac trigger configuration registers
// Five 16-bit registers written through the control channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zct_cfg
   import zct_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [REG_W-1:0]   csr_data,
   output cfg_type            cfg
);

   cfg_type regs_ff;
   cfg_type regs_in;

   assign csr_ready = 1'b1;
   assign cfg       = regs_ff;

   always_comb begin
      regs_in = regs_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_FIRST_CROSS_DELAY: regs_in.first_cross_delay = csr_data;
            REG_TIMEOUT_TICKS:     regs_in.timeout_ticks     = csr_data;
            REG_PULSE_TICKS:       regs_in.pulse_ticks       = csr_data;
            REG_PERIOD_MIN:        regs_in.period_min        = csr_data;
            REG_PERIOD_MAX:        regs_in.period_max        = csr_data;
            default:               regs_in                   = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.first_cross_delay <= RST_FIRST_CROSS_DELAY;
         regs_ff.timeout_ticks     <= RST_TIMEOUT_TICKS;
         regs_ff.pulse_ticks       <= RST_PULSE_TICKS;
         regs_ff.period_min        <= RST_PERIOD_MIN;
         regs_ff.period_max        <= RST_PERIOD_MAX;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

// ----- design/zct_core.sv -----
// ----------------------------------------------------------------------------
// Zero-cross triac trigger core
// Blanking, edge arming, period measurement, one-shot timer and gate
// sequencer, updated once per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zct_core
   import zct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [1:0] mode,
   input  logic       pin_level,
   input  logic       fire_request,
   input  cfg_type    cfg,
   output res_type    res
);

   phase_type          seq_ff,     seq_in;
   logic [BLANK_W-1:0] blank_ff,   blank_in;
   logic               sampled_ff, sampled_in;
   logic               armed_ff,   armed_in;
   count_type          count_ff,   count_in;
   count_type          reload_ff,  reload_in;
   logic               running_ff, running_in;
   count_type          accum_ff,   accum_in;
   count_type          period_ff,  period_in;
   logic               gate_ff,    gate_in;

   logic               tick_go;
   logic               edge_hit;
   logic               edge_go;
   logic               count_go;
   logic               upd;
   logic [BLANK_W-1:0] blank_inc;
   count_type          accum_sum;
   count_type          period_edge;
   logic               in_window;
   count_type          half;
   count_type          half_less_pulse;
   count_type          cfg_first;
   count_type          cfg_timeout;
   count_type          cfg_pulse;

   assign tick_go   = step && (mode == MODE_TICK);
   assign edge_hit  = step && (mode == MODE_EDGE) && armed_ff;
   assign edge_go   = edge_hit && !sampled_ff;
   assign count_go  = step && (mode == MODE_COUNT) && running_ff;
   assign upd       = count_go && (count_ff == reload_ff);
   assign blank_inc = blank_ff + 1'b1;

   assign cfg_first   = COUNT_WIDTH'(cfg.first_cross_delay);
   assign cfg_timeout = COUNT_WIDTH'(cfg.timeout_ticks);
   assign cfg_pulse   = COUNT_WIDTH'(cfg.pulse_ticks);

   // period only counts when the last edge closed a full wait cycle
   assign accum_sum   = accum_ff + count_ff;
   assign period_edge = (seq_ff == PH_WAIT) ? accum_sum : '0;
   assign in_window   = (period_edge >= COUNT_WIDTH'(cfg.period_min)) &&
                        (period_edge <= COUNT_WIDTH'(cfg.period_max));

   assign half            = period_ff >> 1;
   assign half_less_pulse = (half > cfg_pulse) ? (half - cfg_pulse) : '0;

   // sequencer next state
   always_comb begin
      seq_in = seq_ff;
      if (edge_go) begin
         seq_in = in_window ? PH_FIRST : PH_WAIT;
      end else if (upd) begin
         unique case (seq_ff)
            PH_FIRST:  seq_in = fire_request ? PH_PULSE1 : PH_SECOND;
            PH_SECOND: seq_in = fire_request ? PH_PULSE2 : PH_WAIT;
            PH_PULSE1: seq_in = PH_SECOND;
            PH_PULSE2: seq_in = PH_WAIT;
            PH_WAIT:   seq_in = PH_IDLE;
            default:   seq_in = seq_ff;
         endcase
      end
   end

   // timer, measurement and gate updates
   always_comb begin
      blank_in   = blank_ff;
      sampled_in = sampled_ff;
      armed_in   = armed_ff;
      count_in   = count_ff;
      reload_in  = reload_ff;
      running_in = running_ff;
      accum_in   = accum_ff;
      period_in  = period_ff;
      gate_in    = gate_ff;

      if (tick_go) begin
         if (blank_ff < BLANK_W'(BLANK_LIMIT)) begin
            blank_in = blank_inc;
            if (blank_inc == BLANK_W'(ARM_TICK)) begin
               sampled_in = pin_level;
               armed_in   = 1'b1;
            end
         end
      end

      if (edge_hit) begin
         armed_in = 1'b0;
         blank_in = '0;
      end

      if (edge_go) begin
         count_in   = '0;
         period_in  = period_edge;
         reload_in  = in_window ? cfg_first : cfg_timeout;
         gate_in    = 1'b0;
         accum_in   = '0;
         running_in = 1'b1;
      end

      if (count_go) begin
         if (upd) begin
            count_in = '0;
            accum_in = accum_ff + reload_ff;
            case (seq_ff)
               PH_FIRST, PH_SECOND: begin
                  if (fire_request) begin
                     gate_in   = 1'b1;
                     reload_in = cfg_pulse;
                  end else if (seq_ff == PH_FIRST) begin
                     reload_in = half;
                  end else begin
                     reload_in = cfg_timeout;
                  end
               end
               PH_PULSE1: begin
                  gate_in   = 1'b0;
                  reload_in = half_less_pulse;
               end
               PH_PULSE2: begin
                  gate_in   = 1'b0;
                  reload_in = cfg_timeout;
               end
               PH_WAIT: begin
                  period_in  = '0;
                  gate_in    = 1'b0;
                  running_in = 1'b0;
               end
               default: begin
                  gate_in    = 1'b0;
                  running_in = 1'b0;
               end
            endcase
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff     <= PH_IDLE;
         blank_ff   <= '0;
         sampled_ff <= 1'b0;
         armed_ff   <= 1'b0;
         count_ff   <= '0;
         reload_ff  <= COUNT_WIDTH'(RST_TIMEOUT_TICKS);
         running_ff <= 1'b0;
         accum_ff   <= '0;
         period_ff  <= '0;
         gate_ff    <= 1'b0;
      end else begin
         seq_ff     <= seq_in;
         blank_ff   <= blank_in;
         sampled_ff <= sampled_in;
         armed_ff   <= armed_in;
         count_ff   <= count_in;
         reload_ff  <= reload_in;
         running_ff <= running_in;
         accum_ff   <= accum_in;
         period_ff  <= period_in;
         gate_ff    <= gate_in;
      end
   end

   // the response reports the state as it stands after this request
   assign res.gate_on         = gate_in;
   assign res.measured_period = PERIOD_W'(period_in);
   assign res.phase           = seq_in;
   assign res.edge_armed      = armed_in;

endmodule

// ----- design/zero_cross_triac_trigger.sv -----
// ----------------------------------------------------------------------------
// Zero-cross triac trigger
// Mains zero-cross detector and thyristor gate pulser with a one-shot timer.
// ----------------------------------------------------------------------------
// Each request (ms tick, zero-cross edge or timer count, chosen by req_tuser)
// gives exactly one response with the gate drive, the last measured period,
// the sequencer phase and the edge arming flag. The block takes one request
// per clock while the response channel is not stalled. A request is held in
// the input register, the state update runs combinationally into the response
// register, and a response is valid once it has passed both registers.
// The rate is set by that combinational update of the timer and sequencer.
// A stalled response holds the response register and the input register
// still accepts one more request.
// Configuration writes take effect at the next timer reload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zero_cross_triac_trigger
   import zct_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [0] pin_level, [1] fire_request
   input  logic [1:0]         req_tuser,   // [1:0] mode
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata,   // [0] gate_on, [16:1] measured_period,
                                           // [19:17] phase, [20] edge_armed
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [REG_W-1:0]   csr_data
);

   cfg_type    cfg;
   res_type    res;

   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_mode_ff;
   logic       in_pin_ff;
   logic       in_fire_ff;
   logic       out_valid_ff, out_valid_in;
   res_type    out_ff;
   logic       advance;
   logic       take;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   zct_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   zct_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .mode         (in_mode_ff),
      .pin_level    (in_pin_ff),
      .fire_request (in_fire_ff),
      .cfg          (cfg),
      .res          (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_mode_ff <= req_tuser;
         in_pin_ff  <= req_tdata[0];
         in_fire_ff <= req_tdata[1];
      end
      if (advance) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff.edge_armed, out_ff.phase,
                        out_ff.measured_period, out_ff.gate_on};

endmodule

// ----- design/zct_checker.sv -----
// ----------------------------------------------------------------------------
// Zero-cross triac trigger port checker
// Watches the response channel over time and binds to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "zero_cross_triac_trigger_macros.svh"

module zct_checker
   import zct_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   logic [2:0] phase;

   assign phase = rsp_tdata[19:17];

   `ZCT_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")
   `ZCT_ASSERT_ALWAYS(a_rsp_reset, $past(reset) |-> !rsp_tvalid, "response valid right after reset")
   `ZCT_ASSERT(a_gate_phase, rsp_tvalid && rsp_tdata[0] |-> phase == PH_PULSE1 || phase == PH_PULSE2, "gate on outside a pulse phase")
   `ZCT_ASSERT(a_idle_period, rsp_tvalid && phase == PH_IDLE |-> rsp_tdata[16:1] == '0, "idle with a nonzero period")

endmodule

bind zero_cross_triac_trigger zct_checker u_zct_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
